[rtl/smci_pkg.sv]
package smci_pkg;

  // Received bytes with a meaning of their own.
  localparam logic [7:0] NL_BYTE   = 8'h0A;
  localparam logic [7:0] OP_REL    = 8'h72;  // 'r'
  localparam logic [7:0] OP_ABS    = 8'h61;  // 'a'
  localparam logic [7:0] OP_QUERY  = 8'h70;  // 'p'
  localparam logic [7:0] MOT_FWD   = 8'h46;  // 'F'
  localparam logic [7:0] MOT_REV   = 8'h56;  // 'V'
  localparam logic [7:0] MOT_LEFT  = 8'h4C;  // 'L'
  localparam logic [7:0] MOT_RIGHT = 8'h52;  // 'R'
  localparam logic [7:0] MOT_STOP  = 8'h53;  // 'S'
  localparam logic [7:0] MOT_KEEP  = 8'h00;

  // Motor line patterns.
  localparam logic [5:0] LINES_FWD   = 6'h2D;
  localparam logic [5:0] LINES_REV   = 6'h36;
  localparam logic [5:0] LINES_LEFT  = 6'h2E;
  localparam logic [5:0] LINES_RIGHT = 6'h35;
  localparam logic [5:0] LINES_STOP  = 6'h24;
  localparam logic [5:0] EN_BITS     = 6'h24;

  localparam int unsigned LINE_LEN = 5;
  localparam int unsigned CNT_W    = 3;

  // Configuration register indexes.
  localparam logic [2:0] CFG_S1_MIN = 3'd0;
  localparam logic [2:0] CFG_S1_MAX = 3'd1;
  localparam logic [2:0] CFG_S2_MIN = 3'd2;
  localparam logic [2:0] CFG_S2_MAX = 3'd3;
  localparam logic [2:0] CFG_S3_MIN = 3'd4;
  localparam logic [2:0] CFG_S3_MAX = 3'd5;
  localparam logic [2:0] CFG_BASE   = 3'd6;

  localparam logic [14:0] S1_RESET = 15'd1500;
  localparam logic [14:0] S2_RESET = 15'd1350;
  localparam logic [14:0] S3_RESET = 15'd1050;

  typedef struct packed {
    logic        is_nl;
    logic [7:0]  op;
    logic [7:0]  p1;
    logic [7:0]  p2;
    logic [7:0]  p3;
    logic [7:0]  motor;
  } cmd_t;

  typedef struct packed {
    logic [14:0] s1_min;
    logic [14:0] s1_max;
    logic [14:0] s2_min;
    logic [14:0] s2_max;
    logic [14:0] s3_min;
    logic [14:0] s3_max;
    logic [14:0] base;
  } cfg_t;

  typedef struct packed {
    logic [14:0] servo1_pos;
    logic [14:0] servo2_pos;
    logic [14:0] servo3_pos;
    logic [5:0]  motor_lines;
    logic [14:0] query_position;
    logic        query_valid;
    logic        line_done;
  } res_t;

endpackage

[rtl/servo_motor_command_interpreter.sv]
// Servo and motor command interpreter.
// Input channel: one received serial byte per word on in_rx_byte, taken when
// in_push is high and in_full is low. Bytes build a command line of up to five
// bytes (opcode, three signed servo steps, motor byte); a newline runs it.
// Result channel: every input byte yields exactly one result word: the three
// servo positions and motor lines after that byte, a query report for a 'p'
// line, and line_done for a newline. It is valid while out_empty is low and
// is taken with out_pop.
// Configuration: cfg_index selects one of the seven limit and base registers,
// cfg_data is written when cfg_valid is high; cfg_ready is always high.
// A byte taken is written into the command queue, and its result is written into
// the result queue when that word is popped. Throughput: one byte per cycle while
// in_full is low; the add and clamp in the execute stage are combinational.
// A two-word queue sits between the line assembler and the execute stage and
// another holds results, so input keeps flowing while the receiver stalls
// until both queues are full; then in_full rises.
// Reset: synchronous, active low; clears both queues and the line, loads the
// default limits and servo positions and clears the motor lines.
module servo_motor_command_interpreter (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  input  logic [7:0]  in_rx_byte,
  output logic        in_full,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [14:0] out_servo1_pos,
  output logic [14:0] out_servo2_pos,
  output logic [14:0] out_servo3_pos,
  output logic [5:0]  out_motor_lines,
  output logic [14:0] out_query_position,
  output logic        out_query_valid,
  output logic        out_line_done,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [14:0] cfg_data
);
  import smci_pkg::*;

  cfg_t  cfg_r;
  cmd_t  cmd_in;
  cmd_t  cmd_out;
  res_t  res_in;
  res_t  res_out;
  logic  cmd_push;
  logic  cmd_full;
  logic  cmd_empty;
  logic  cmd_pop;
  logic  res_push;
  logic  res_full;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{s1_min: 15'd1000, s1_max: 15'd2000, s2_min: 15'd1350,
                 s2_max: 15'd1650, s3_min: 15'd1050, s3_max: 15'd1500,
                 base: 15'd1000};
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_S1_MIN: cfg_r.s1_min <= cfg_data;
        CFG_S1_MAX: cfg_r.s1_max <= cfg_data;
        CFG_S2_MIN: cfg_r.s2_min <= cfg_data;
        CFG_S2_MAX: cfg_r.s2_max <= cfg_data;
        CFG_S3_MIN: cfg_r.s3_min <= cfg_data;
        CFG_S3_MAX: cfg_r.s3_max <= cfg_data;
        CFG_BASE:   cfg_r.base   <= cfg_data;
        default:    ;
      endcase
    end
  end

  smci_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_push    (in_push),
    .in_rx_byte (in_rx_byte),
    .in_full    (in_full),
    .cmd_push   (cmd_push),
    .cmd_data   (cmd_in),
    .cmd_full   (cmd_full)
  );

  smci_fifo #(.W($bits(cmd_t))) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (cmd_push),
    .wdata (cmd_in),
    .full  (cmd_full),
    .pop   (cmd_pop),
    .rdata (cmd_out),
    .empty (cmd_empty)
  );

  smci_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .cmd_empty (cmd_empty),
    .cmd_data  (cmd_out),
    .cmd_pop   (cmd_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res_data  (res_in)
  );

  smci_fifo #(.W($bits(res_t))) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res_in),
    .full  (res_full),
    .pop   (out_pop),
    .rdata (res_out),
    .empty (out_empty)
  );

  assign out_servo1_pos     = res_out.servo1_pos;
  assign out_servo2_pos     = res_out.servo2_pos;
  assign out_servo3_pos     = res_out.servo3_pos;
  assign out_motor_lines    = res_out.motor_lines;
  assign out_query_position = res_out.query_position;
  assign out_query_valid    = res_out.query_valid;
  assign out_line_done      = res_out.line_done;

endmodule

[rtl/smci_fifo.sv]
module smci_fifo #(
  parameter int unsigned W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         empty
);

  logic [W-1:0] mem_r [2];
  logic         wr_ptr_r;
  logic         rd_ptr_r;
  logic [1:0]   count_r;
  logic [1:0]   count_nxt;
  logic         do_push;
  logic         do_pop;

  assign full    = (count_r == 2'd2);
  assign empty   = (count_r == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 2'd1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      count_r <= count_nxt;
      if (do_push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r != 2'd3)
    else $error("queue count out of range");

  a_ptr_match: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == 2'd0 || count_r == 2'd2) |-> (wr_ptr_r == rd_ptr_r))
    else $error("queue pointers disagree with count");

  a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (do_push && !do_pop) |=> !empty)
    else $error("queue empty after a word was written");

endmodule

[rtl/smci_front.sv]
module smci_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  input  logic [7:0]         in_rx_byte,
  output logic               in_full,
  output logic               cmd_push,
  output smci_pkg::cmd_t     cmd_data,
  input  logic               cmd_full
);
  import smci_pkg::*;

  logic [7:0]       line_r [LINE_LEN];
  logic [CNT_W-1:0] cnt_r;
  logic             accept;
  logic             is_nl;

  assign in_full  = cmd_full;
  assign accept   = in_push && !cmd_full;
  assign is_nl    = (in_rx_byte == NL_BYTE);
  assign cmd_push = accept;

  // Every byte produces a word with the stored line; only a newline word acts on it.
  assign cmd_data = '{is_nl: is_nl, op: line_r[0], p1: line_r[1], p2: line_r[2],
                      p3: line_r[3], motor: line_r[4]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      for (int i = 0; i < LINE_LEN; i++) begin
        line_r[i] <= '0;
      end
    end else if (accept) begin
      if (is_nl) begin
        cnt_r <= '0;
        for (int i = 0; i < LINE_LEN; i++) begin
          line_r[i] <= '0;
        end
      end else if (cnt_r < CNT_W'(LINE_LEN)) begin
        line_r[cnt_r] <= in_rx_byte;
        cnt_r         <= cnt_r + CNT_W'(1);
      end
    end
  end

  a_nl_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && is_nl) |=> (cnt_r == '0 && line_r[0] == 8'h00))
    else $error("line not cleared after newline");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(LINE_LEN))
    else $error("line count beyond line length");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (in_push && cmd_full) |=> $stable(cnt_r))
    else $error("line changed while the queue was full");

endmodule

[rtl/smci_back.sv]
module smci_back (
  input  logic               clk,
  input  logic               rst_n,
  input  smci_pkg::cfg_t     cfg,
  input  logic               cmd_empty,
  input  smci_pkg::cmd_t     cmd_data,
  output logic               cmd_pop,
  input  logic               res_full,
  output logic               res_push,
  output smci_pkg::res_t     res_data
);
  import smci_pkg::*;

  logic [14:0] servo1_r, servo1_nxt;
  logic [14:0] servo2_r, servo2_nxt;
  logic [14:0] servo3_r, servo3_nxt;
  logic [5:0]  motor_r, motor_nxt;
  logic [14:0] qpos;
  logic        qvalid;
  logic        is_move;

  function automatic logic [16:0] target(input logic [14:0] start, input logic [7:0] p);
    logic signed [16:0] step;
    step = $signed({{6{p[7]}}, p, 3'b000});
    return 17'($signed({2'b00, start}) + step);
  endfunction

  // Max test first, so crossed limits resolve to max.
  function automatic logic [14:0] clamp(input logic [16:0] v, input logic [14:0] lo,
                                        input logic [14:0] hi);
    logic [14:0] r;
    if ($signed(v) > $signed({2'b00, hi})) begin
      r = hi;
    end else if ($signed(v) < $signed({2'b00, lo})) begin
      r = lo;
    end else begin
      r = v[14:0];
    end
    return r;
  endfunction

  assign cmd_pop  = !cmd_empty && !res_full;
  assign res_push = cmd_pop;
  assign is_move  = cmd_data.is_nl && (cmd_data.op == OP_REL || cmd_data.op == OP_ABS);

  always_comb begin
    servo1_nxt = servo1_r;
    servo2_nxt = servo2_r;
    servo3_nxt = servo3_r;
    motor_nxt  = motor_r;
    qpos       = '0;
    qvalid     = 1'b0;
    if (cmd_data.is_nl) begin
      if (cmd_data.op == OP_REL) begin
        servo1_nxt = clamp(target(servo1_r, cmd_data.p1), cfg.s1_min, cfg.s1_max);
        servo2_nxt = clamp(target(servo2_r, cmd_data.p2), cfg.s2_min, cfg.s2_max);
        servo3_nxt = clamp(target(servo3_r, cmd_data.p3), cfg.s3_min, cfg.s3_max);
      end else if (cmd_data.op == OP_ABS) begin
        servo1_nxt = clamp(target(cfg.base, cmd_data.p1), cfg.s1_min, cfg.s1_max);
        servo2_nxt = clamp(target(cfg.base, cmd_data.p2), cfg.s2_min, cfg.s2_max);
        servo3_nxt = clamp(target(cfg.base, cmd_data.p3), cfg.s3_min, cfg.s3_max);
      end else if (cmd_data.op == OP_QUERY) begin
        qvalid = 1'b1;
        if (cmd_data.p1 != 8'h00) begin
          qpos = servo1_r;
        end else if (cmd_data.p2 != 8'h00) begin
          qpos = servo2_r;
        end else if (cmd_data.p3 != 8'h00) begin
          qpos = servo3_r;
        end
      end
      case (cmd_data.motor)
        MOT_FWD:   motor_nxt = LINES_FWD;
        MOT_REV:   motor_nxt = LINES_REV;
        MOT_LEFT:  motor_nxt = LINES_LEFT;
        MOT_RIGHT: motor_nxt = LINES_RIGHT;
        MOT_STOP:  motor_nxt = LINES_STOP;
        MOT_KEEP:  motor_nxt = motor_r;
        default:   motor_nxt = motor_r & ~EN_BITS;
      endcase
    end
  end

  assign res_data = '{servo1_pos: servo1_nxt, servo2_pos: servo2_nxt,
                      servo3_pos: servo3_nxt, motor_lines: motor_nxt,
                      query_position: qpos, query_valid: qvalid,
                      line_done: cmd_data.is_nl};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      servo1_r <= S1_RESET;
      servo2_r <= S2_RESET;
      servo3_r <= S3_RESET;
      motor_r  <= '0;
    end else if (cmd_pop) begin
      servo1_r <= servo1_nxt;
      servo2_r <= servo2_nxt;
      servo3_r <= servo3_nxt;
      motor_r  <= motor_nxt;
    end
  end

  a_plain_byte_keeps: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd_pop && !cmd_data.is_nl) |=>
      ($stable(servo1_r) && $stable(servo2_r) && $stable(servo3_r) && $stable(motor_r)))
    else $error("state changed on a byte that is not a newline");

  a_query_no_move: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd_pop && qvalid) |-> (!is_move && servo1_nxt == servo1_r))
    else $error("query command moved a servo");

  a_no_pop_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !cmd_pop |=> ($stable(servo1_r) && $stable(motor_r)))
    else $error("state changed without a command");

endmodule

[verif/tb_servo_motor_command_interpreter.sv]
module tb_servo_motor_command_interpreter;
  timeunit 1ns;
  timeprecision 1ps;

  import smci_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int unsigned RANDOM_BYTES  = 950;
  localparam int unsigned NUM_PHASES    = 8;
  localparam int unsigned SETTLE_CYCLES = 4;

  localparam logic [2:0] MIN_IDX [3] = '{CFG_S1_MIN, CFG_S2_MIN, CFG_S3_MIN};
  localparam logic [2:0] MAX_IDX [3] = '{CFG_S1_MAX, CFG_S2_MAX, CFG_S3_MAX};

  typedef struct {
    logic [7:0] rx;
    bit         typed;
    res_t       want;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_push = 1'b0;
  logic [7:0]  in_rx_byte = '0;
  logic        in_full;
  logic        out_empty;
  logic        out_pop = 1'b0;
  logic [14:0] out_servo1_pos;
  logic [14:0] out_servo2_pos;
  logic [14:0] out_servo3_pos;
  logic [5:0]  out_motor_lines;
  logic [14:0] out_query_position;
  logic        out_query_valid;
  logic        out_line_done;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [14:0] cfg_data = '0;

  // Typed expectation that travels with the byte currently offered.
  bit          row_typed = 1'b0;
  res_t        row_want = '0;

  // Predictor state.
  logic [7:0]  line_buf [LINE_LEN];
  int unsigned line_fill;
  logic [14:0] servo_pos [3];
  logic [5:0]  motor_state;
  logic [14:0] cfg_reg [7];

  res_t        pending_results [$];
  int unsigned error_cnt = 0;
  int unsigned cycle_cnt = 0;
  int unsigned sent_cnt = 0;
  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;

  servo_motor_command_interpreter u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_push            (in_push),
    .in_rx_byte         (in_rx_byte),
    .in_full            (in_full),
    .out_empty          (out_empty),
    .out_pop            (out_pop),
    .out_servo1_pos     (out_servo1_pos),
    .out_servo2_pos     (out_servo2_pos),
    .out_servo3_pos     (out_servo3_pos),
    .out_motor_lines    (out_motor_lines),
    .out_query_position (out_query_position),
    .out_query_valid    (out_query_valid),
    .out_line_done      (out_line_done),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void reset_model();
    foreach (line_buf[k]) line_buf[k] = '0;
    line_fill = 0;
    servo_pos[0] = S1_RESET;
    servo_pos[1] = S2_RESET;
    servo_pos[2] = S3_RESET;
    motor_state = '0;
    cfg_reg[CFG_S1_MIN] = 15'd1000;
    cfg_reg[CFG_S1_MAX] = 15'd2000;
    cfg_reg[CFG_S2_MIN] = 15'd1350;
    cfg_reg[CFG_S2_MAX] = 15'd1650;
    cfg_reg[CFG_S3_MIN] = 15'd1050;
    cfg_reg[CFG_S3_MAX] = 15'd1500;
    cfg_reg[CFG_BASE]   = 15'd1000;
  endfunction

  // The upper limit is tested first, so crossed limits resolve to max.
  function automatic logic [14:0] clamp_pos(int v, logic [14:0] lo, logic [14:0] hi);
    int lo_i;
    int hi_i;
    lo_i = lo;
    hi_i = hi;
    if (v > hi_i) return hi;
    if (v < lo_i) return lo;
    return v[14:0];
  endfunction

  function automatic res_t interpret_byte(logic [7:0] b);
    res_t       r;
    int         step [3];
    int         origin;
    logic [7:0] op;
    r = '0;
    if (b == NL_BYTE) begin
      op = line_buf[0];
      for (int k = 0; k < 3; k++) step[k] = $signed(line_buf[k + 1]);
      r.line_done = 1'b1;
      if (op == OP_REL || op == OP_ABS) begin
        for (int k = 0; k < 3; k++) begin
          if (op == OP_REL) origin = servo_pos[k];
          else origin = cfg_reg[CFG_BASE];
          servo_pos[k] = clamp_pos(origin + 8 * step[k], cfg_reg[MIN_IDX[k]],
                                   cfg_reg[MAX_IDX[k]]);
        end
      end else if (op == OP_QUERY) begin
        r.query_valid = 1'b1;
        if (step[0] != 0) r.query_position = servo_pos[0];
        else if (step[1] != 0) r.query_position = servo_pos[1];
        else if (step[2] != 0) r.query_position = servo_pos[2];
      end
      case (line_buf[4])
        MOT_FWD:   motor_state = LINES_FWD;
        MOT_REV:   motor_state = LINES_REV;
        MOT_LEFT:  motor_state = LINES_LEFT;
        MOT_RIGHT: motor_state = LINES_RIGHT;
        MOT_STOP:  motor_state = LINES_STOP;
        MOT_KEEP:  ;
        default:   motor_state = motor_state & ~EN_BITS;
      endcase
      foreach (line_buf[k]) line_buf[k] = '0;
      line_fill = 0;
    end else if (line_fill < LINE_LEN) begin
      line_buf[line_fill] = b;
      line_fill++;
    end
    r.servo1_pos  = servo_pos[0];
    r.servo2_pos  = servo_pos[1];
    r.servo3_pos  = servo_pos[2];
    r.motor_lines = motor_state;
    return r;
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      error_cnt++;
      $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin : monitor
    res_t got;
    res_t want;
    res_t model;
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      out_pop <= ($urandom_range(99) >= stall_pct);
      if (rst_n) begin
        if (cfg_valid && cfg_ready) cfg_reg[cfg_index] = cfg_data;
        if (in_push && !in_full) begin
          model = interpret_byte(in_rx_byte);
          if (row_typed) pending_results.push_back(row_want);
          else pending_results.push_back(model);
        end
        if (out_pop && !out_empty) begin
          if (pending_results.size() == 0) begin
            error_cnt++;
            $display("%0t: result word with no expectation waiting", $time);
          end else begin
            want = pending_results.pop_front();
            got.servo1_pos     = out_servo1_pos;
            got.servo2_pos     = out_servo2_pos;
            got.servo3_pos     = out_servo3_pos;
            got.motor_lines    = out_motor_lines;
            got.query_position = out_query_position;
            got.query_valid    = out_query_valid;
            got.line_done      = out_line_done;
            check_field("servo1_pos", want.servo1_pos, got.servo1_pos);
            check_field("servo2_pos", want.servo2_pos, got.servo2_pos);
            check_field("servo3_pos", want.servo3_pos, got.servo3_pos);
            check_field("motor_lines", want.motor_lines, got.motor_lines);
            check_field("query_position", want.query_position, got.query_position);
            check_field("query_valid", want.query_valid, got.query_valid);
            check_field("line_done", want.line_done, got.line_done);
          end
        end
      end
    end
  end

  task automatic send_byte(logic [7:0] b, bit typed, res_t want);
    while ($urandom_range(99) < idle_pct) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push    <= 1'b1;
    in_rx_byte <= b;
    row_typed  <= typed;
    row_want   <= want;
    do @(posedge clk); while (in_full);
    sent_cnt++;
  endtask

  task automatic send_free(logic [7:0] b);
    send_byte(b, 1'b0, '0);
  endtask

  // Sender stops until every expected word has come back.
  task automatic drain();
    in_push <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [14:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic set_config(logic [14:0] s1_lo, logic [14:0] s1_hi, logic [14:0] s2_lo,
                            logic [14:0] s2_hi, logic [14:0] s3_lo, logic [14:0] s3_hi,
                            logic [14:0] base);
    write_reg(CFG_S1_MIN, s1_lo);
    write_reg(CFG_S1_MAX, s1_hi);
    write_reg(CFG_S2_MIN, s2_lo);
    write_reg(CFG_S2_MAX, s2_hi);
    write_reg(CFG_S3_MIN, s3_lo);
    write_reg(CFG_S3_MAX, s3_hi);
    write_reg(CFG_BASE, base);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [7:0] pick_step();
    int s;
    if ($urandom_range(1)) return 8'($urandom_range(255));
    s = int'($urandom_range(16)) - 8;
    return s[7:0];
  endfunction

  function automatic logic [7:0] pick_motor();
    case ($urandom_range(6))
      0:       return MOT_FWD;
      1:       return MOT_REV;
      2:       return MOT_LEFT;
      3:       return MOT_RIGHT;
      4:       return MOT_STOP;
      5:       return MOT_KEEP;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // Mostly complete command lines; some short, long or with an unknown opcode.
  task automatic send_random_line();
    logic [7:0] op;
    int         n_args;
    case ($urandom_range(9))
      0, 1, 2: op = OP_REL;
      3, 4, 5: op = OP_ABS;
      6, 7:    op = OP_QUERY;
      default: op = 8'($urandom_range(255));
    endcase
    if ($urandom_range(9) < 7) n_args = 4;
    else n_args = $urandom_range(7);
    send_free(op);
    for (int i = 1; i <= n_args; i++) begin
      if (i <= 3) send_free(pick_step());
      else if (i == 4) send_free(pick_motor());
      else send_free(8'($urandom_range(255)));
    end
    send_free(NL_BYTE);
  endtask

  function automatic stim_row_t row_free(logic [7:0] b);
    stim_row_t r;
    r.rx    = b;
    r.typed = 1'b0;
    r.want  = '0;
    return r;
  endfunction

  function automatic stim_row_t row_want_is(logic [7:0] b, logic [14:0] s1, logic [14:0] s2,
                                            logic [14:0] s3, logic [5:0] m, logic [14:0] q,
                                            logic qv, logic ld);
    stim_row_t r;
    r.rx                  = b;
    r.typed               = 1'b1;
    r.want.servo1_pos     = s1;
    r.want.servo2_pos     = s2;
    r.want.servo3_pos     = s3;
    r.want.motor_lines    = m;
    r.want.query_position = q;
    r.want.query_valid    = qv;
    r.want.line_done      = ld;
    return r;
  endfunction

  initial begin
    stim_row_t   directed [$];
    int unsigned target;
    int unsigned mid;
    reset_model();
    directed = '{
      row_want_is(OP_QUERY, 15'd1500, 15'd1350, 15'd1050, '0, '0, 1'b0, 1'b0),
      row_free(8'h01), row_free(8'h00), row_free(8'h00), row_free(MOT_FWD),
      row_want_is(NL_BYTE, 15'd1500, 15'd1350, 15'd1050, LINES_FWD, 15'd1500, 1'b1, 1'b1),
      // Steps from the base push every servo past one of its limits.
      row_free(OP_ABS), row_free(8'h7F), row_free(8'h80), row_free(8'hFF), row_free(8'h5A),
      row_want_is(NL_BYTE, 15'd2000, 15'd1350, 15'd1050, LINES_FWD & ~EN_BITS, '0, 1'b0,
                  1'b1),
      // The sixth byte of a line is dropped.
      row_free(OP_REL), row_free(8'h80), row_free(8'h05), row_free(8'h06), row_free(MOT_REV),
      row_free(8'hFF),
      row_want_is(NL_BYTE, 15'd1000, 15'd1390, 15'd1098, LINES_REV, '0, 1'b0, 1'b1),
      row_free(8'h71),
      row_want_is(NL_BYTE, 15'd1000, 15'd1390, 15'd1098, LINES_REV, '0, 1'b0, 1'b1),
      row_want_is(NL_BYTE, 15'd1000, 15'd1390, 15'd1098, LINES_REV, '0, 1'b0, 1'b1),
      row_free(OP_QUERY),
      row_want_is(NL_BYTE, 15'd1000, 15'd1390, 15'd1098, LINES_REV, '0, 1'b1, 1'b1)
    };

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) send_byte(directed[i].rx, directed[i].typed, directed[i].want);
    drain();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 46; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 46; end
        default: begin idle_pct = 24; stall_pct = 24; end
      endcase
      case (ph)
        0: ;
        1: set_config(15'd0, 15'd20000, 15'd0, 15'd20000, 15'd0, 15'd20000, 15'd0);
        2: set_config(15'd20000, 15'd20000, 15'd20000, 15'd20000, 15'd20000, 15'd20000,
                      15'd20000);
        3: set_config('0, '0, '0, '0, '0, '0, '0);
        4: set_config(15'd1600, 15'd1400, 15'd2000, 15'd1000, 15'd20000, 15'd0, 15'd1500);
        5: set_config(15'($urandom_range(500, 1500)), 15'($urandom_range(1500, 2500)),
                      15'($urandom_range(500, 1500)), 15'($urandom_range(1500, 2500)),
                      15'($urandom_range(500, 1500)), 15'($urandom_range(1500, 2500)),
                      15'($urandom_range(800, 1600)));
        6: set_config(15'($urandom_range(20000)), 15'($urandom_range(20000)),
                      15'($urandom_range(20000)), 15'($urandom_range(20000)),
                      15'($urandom_range(20000)), 15'($urandom_range(20000)),
                      15'($urandom_range(20000)));
        default: set_config(15'd1000, 15'd2000, 15'd1350, 15'd1650, 15'd1050, 15'd1500,
                            15'd1000);
      endcase
      target = sent_cnt + RANDOM_BYTES / NUM_PHASES;
      mid    = sent_cnt + RANDOM_BYTES / (2 * NUM_PHASES);
      while (sent_cnt < mid) send_random_line();
      drain();
      while (sent_cnt < target) send_random_line();
      drain();
    end

    repeat (10) @(posedge clk);
    if (error_cnt == 0 && pending_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
